// ===== hdl/llvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llvs_pkg
// Shared types and constants of the lane lead vehicle speed selector.
// ----------------------------------------------------------------------------
package llvs_pkg;

  localparam int POS_FRAC_BITS = 8;

  localparam int CENTER_W = 15;
  localparam int HALF_W   = 12;
  localparam int GAP_W    = 16;
  localparam int SPEED_W  = 15;
  localparam int POS_W    = 21;
  localparam int VEL_W    = 16;
  localparam int PROD_W   = 2 * VEL_W;
  localparam int ROOT_W   = PROD_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_CNT_W = $clog2(ROOT_STEPS);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [CENTER_W-1:0] LANE_CENTER_RST = CENTER_W'(64'd6 << POS_FRAC_BITS);
  localparam logic [HALF_W-1:0]   HALF_WIDTH_RST  = HALF_W'(64'd3 << POS_FRAC_BITS);
  localparam logic [GAP_W-1:0]    LOOK_AHEAD_RST  = GAP_W'(64'd100 << POS_FRAC_BITS);
  localparam logic [SPEED_W-1:0]  SPEED_LIMIT_RST =
    SPEED_W'(((64'd2123440 << POS_FRAC_BITS) + 64'd50000) / 64'd100000);

  typedef enum logic [1:0] {
    REG_LANE_CENTER,
    REG_HALF_WIDTH,
    REG_LOOK_AHEAD,
    REG_SPEED_LIMIT
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_VX,
    MUL_VY,
    MUL_LIM
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     eval;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     root_start;
    logic     root_step;
    logic     res_limit;
    logic     res_root;
    logic     out_load;
  } llvs_cmd_t;

  typedef struct packed {
    logic lead_seen;
    logic last;
    logic mag_below;
  } llvs_stat_t;

endpackage

// ===== hdl/lane_lead_vehicle_speed_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_lead_vehicle_speed_select
// Picks the nearest in-lane vehicle ahead of the ego position in each scan
// and reports the target speed: the cap, or the lead vehicle's speed if lower.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one tracked vehicle per item, with scan_last set on
// the final item of a scan; an item with car_valid low carries no vehicle.
// The output channel gives one item per scan: target_speed and lead_found.
// The user is to write the configuration registers over the APB-style port
// while idle; the block does not enforce this. look_ahead is sampled at the
// first item of each scan. An item that does not end a scan is captured and
// then put through the lane and gap compare before the next item is taken.
// A scan-end item gives the cap as its result when no lead was found; else
// three passes through the shared squaring multiplier form the lead's squared
// speed and the squared cap, the cap is the result when the lead is at or
// above it, and the 16-step bit-serial square root gives the lead's speed.
// A finished result waits in the output register; if the receiver stalls,
// the next item is still taken and evaluated, and a new result waits until
// the previous one has been taken.
// Reset restores the register defaults and closes any open scan.
// ----------------------------------------------------------------------------
module lane_lead_vehicle_speed_select
  import llvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      ego_s,
  input  logic                  car_valid,
  input  logic [POS_W-1:0]      car_s,
  input  logic [CENTER_W-1:0]   car_d,
  input  logic [VEL_W-1:0]      car_vx,
  input  logic [VEL_W-1:0]      car_vy,
  input  logic                  scan_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SPEED_W-1:0]    target_speed,
  output logic                  lead_found
);

  logic [CENTER_W-1:0] lane_center_d;
  logic [HALF_W-1:0]   lane_half_width;
  logic [GAP_W-1:0]    look_ahead;
  logic [SPEED_W-1:0]  speed_limit;
  llvs_cmd_t           cmd;
  llvs_stat_t          stat;

  llvs_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .lane_center_d   (lane_center_d),
    .lane_half_width (lane_half_width),
    .look_ahead      (look_ahead),
    .speed_limit     (speed_limit)
  );

  llvs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .lane_center_d   (lane_center_d),
    .lane_half_width (lane_half_width),
    .look_ahead      (look_ahead),
    .speed_limit     (speed_limit),
    .ego_s           (ego_s),
    .car_valid       (car_valid),
    .car_s           (car_s),
    .car_d           (car_d),
    .car_vx          (car_vx),
    .car_vy          (car_vy),
    .scan_last       (scan_last),
    .target_speed    (target_speed),
    .lead_found      (lead_found)
  );

  llvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

endmodule

// ===== hdl/llvs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llvs_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module llvs_cfg
  import llvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CENTER_W-1:0]   lane_center_d,
  output logic [HALF_W-1:0]     lane_half_width,
  output logic [GAP_W-1:0]      look_ahead,
  output logic [SPEED_W-1:0]    speed_limit
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_center_d   <= LANE_CENTER_RST;
      lane_half_width <= HALF_WIDTH_RST;
      look_ahead      <= LOOK_AHEAD_RST;
      speed_limit     <= SPEED_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LANE_CENTER: lane_center_d   <= pwdata[CENTER_W-1:0];
        REG_HALF_WIDTH:  lane_half_width <= pwdata[HALF_W-1:0];
        REG_LOOK_AHEAD:  look_ahead      <= pwdata[GAP_W-1:0];
        REG_SPEED_LIMIT: speed_limit     <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LANE_CENTER: prdata = {{(APB_DATA_W-CENTER_W){lane_center_d[CENTER_W-1]}},
                                 lane_center_d};
      REG_HALF_WIDTH:  prdata = {{(APB_DATA_W-HALF_W){1'b0}}, lane_half_width};
      REG_LOOK_AHEAD:  prdata = {{(APB_DATA_W-GAP_W){1'b0}}, look_ahead};
      REG_SPEED_LIMIT: prdata = {{(APB_DATA_W-SPEED_W){1'b0}}, speed_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hdl/llvs_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llvs_isqrt
// Restoring integer square root, one result bit per step.
// ----------------------------------------------------------------------------
module llvs_isqrt
  import llvs_pkg::*;
(
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [PROD_W-1:0] x,
  output logic [ROOT_W-1:0] root
);

  logic [PROD_W-1:0] rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  assign rem_sh = {rem, rad[PROD_W-1:PROD_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= x;
      rem  <= '0;
      root <= '0;
    end else if (step) begin
      rad  <= {rad[PROD_W-3:0], 2'b00};
      rem  <= fits ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/llvs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llvs_dp
// Datapath: item capture, lane and gap test, lead tracking, speed magnitude.
// ----------------------------------------------------------------------------
module llvs_dp
  import llvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  llvs_cmd_t           cmd,
  output llvs_stat_t          stat,
  input  logic [CENTER_W-1:0] lane_center_d,
  input  logic [HALF_W-1:0]   lane_half_width,
  input  logic [GAP_W-1:0]    look_ahead,
  input  logic [SPEED_W-1:0]  speed_limit,
  input  logic [POS_W-1:0]    ego_s,
  input  logic                car_valid,
  input  logic [POS_W-1:0]    car_s,
  input  logic [CENTER_W-1:0] car_d,
  input  logic [VEL_W-1:0]    car_vx,
  input  logic [VEL_W-1:0]    car_vy,
  input  logic                scan_last,
  output logic [SPEED_W-1:0]  target_speed,
  output logic                lead_found
);

  localparam int WIN_W = CENTER_W + 2;

  logic [POS_W-1:0]    it_ego;
  logic                it_valid;
  logic [POS_W-1:0]    it_s;
  logic [CENTER_W-1:0] it_d;
  logic [VEL_W-1:0]    it_vx;
  logic [VEL_W-1:0]    it_vy;
  logic                it_last;

  logic                scan_open;
  logic [GAP_W-1:0]    best_gap;
  logic                lead_seen;
  logic [VEL_W-1:0]    lead_vx;
  logic [VEL_W-1:0]    lead_vy;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   acc;
  logic [SPEED_W-1:0]  res_speed;
  logic [ROOT_W-1:0]   root;

  logic signed [WIN_W-1:0] center_x, half_x, d_x, win_lo, win_hi;
  logic [POS_W:0]      diff;
  logic [GAP_W-1:0]    best_eff;
  logic                seen_eff, in_lane, ahead, closer, take;
  logic [VEL_W-1:0]    mul_op;

  assign center_x = WIN_W'(signed'(lane_center_d));
  assign half_x   = signed'({{(WIN_W-HALF_W){1'b0}}, lane_half_width});
  assign d_x      = WIN_W'(signed'(it_d));
  assign win_lo   = center_x - half_x;
  assign win_hi   = center_x + half_x;
  assign in_lane  = (d_x >= win_lo) && (d_x <= win_hi);

  assign diff     = {1'b0, it_s} - {1'b0, it_ego};
  assign best_eff = scan_open ? best_gap : look_ahead;
  assign seen_eff = scan_open && lead_seen;
  assign ahead    = !diff[POS_W] && (diff[POS_W-1:0] != '0);
  assign closer   = (diff[POS_W-1:GAP_W] == '0) && (diff[GAP_W-1:0] < best_eff);
  assign take     = it_valid && in_lane && ahead && closer;

  always_comb begin
    case (cmd.mul_sel)
      MUL_VX:  mul_op = lead_vx[VEL_W-1] ? VEL_W'(~lead_vx + 1'b1) : lead_vx;
      MUL_VY:  mul_op = lead_vy[VEL_W-1] ? VEL_W'(~lead_vy + 1'b1) : lead_vy;
      default: mul_op = {{(VEL_W-SPEED_W){1'b0}}, speed_limit};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_ego   <= ego_s;
      it_valid <= car_valid;
      it_s     <= car_s;
      it_d     <= car_d;
      it_vx    <= car_vx;
      it_vy    <= car_vy;
      it_last  <= scan_last;
    end
    if (cmd.eval) begin
      best_gap <= take ? diff[GAP_W-1:0] : best_eff;
      if (take) begin
        lead_vx <= it_vx;
        lead_vy <= it_vy;
      end
    end
    if (cmd.mul_en) begin
      prod <= mul_op * mul_op;
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.res_limit) begin
      res_speed <= speed_limit;
    end else if (cmd.res_root) begin
      res_speed <= root[SPEED_W-1:0];
    end
    if (cmd.out_load) begin
      target_speed <= res_speed;
      lead_found   <= lead_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_open <= 1'b0;
      lead_seen <= 1'b0;
    end else if (cmd.eval) begin
      scan_open <= 1'b1;
      lead_seen <= take || seen_eff;
    end else if (cmd.out_load) begin
      scan_open <= 1'b0;
    end
  end

  llvs_isqrt u_isqrt (
    .clk   (clk),
    .start (cmd.root_start),
    .step  (cmd.root_step),
    .x     (acc),
    .root  (root)
  );

  assign stat.lead_seen = lead_seen;
  assign stat.last      = it_last;
  assign stat.mag_below = acc < prod;

  a_root_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.res_root |=> res_speed < speed_limit)
    else $error("square root result reached the speed limit");

  a_eval_opens_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> scan_open)
    else $error("scan not open after an item was evaluated");

  a_lead_in_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(lead_seen) |-> scan_open)
    else $error("lead vehicle recorded outside a scan");

endmodule

// ===== hdl/llvs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llvs_ctrl
// Controller: sequences item evaluation, squaring, square root and output.
// ----------------------------------------------------------------------------
module llvs_ctrl
  import llvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  llvs_stat_t stat,
  output llvs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQX,
    ST_SQY,
    ST_SQL,
    ST_CMP,
    ST_ROOT,
    ST_RES,
    ST_FINISH
  } state_t;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(ROOT_STEPS - 1);

  state_t                state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_VX;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.last ? ST_SQX : ST_IDLE;
      end
      ST_SQX: begin
        if (stat.lead_seen) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_VX;
          state_next  = ST_SQY;
        end else begin
          cmd.res_limit = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_SQY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_VY;
        cmd.acc_load = 1'b1;
        state_next   = ST_SQL;
      end
      ST_SQL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LIM;
        cmd.acc_add = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        if (stat.mag_below) begin
          cmd.root_start = 1'b1;
          state_next     = ST_ROOT;
        end else begin
          cmd.res_limit = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = ST_RES;
        end
      end
      ST_RES: begin
        cmd.res_root = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ROOT) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_root_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) && (step_cnt == LAST_STEP) |=> state == ST_RES)
    else $error("square root did not end after its last step");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is being evaluated");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before it was taken");

endmodule
